// ===== rtl/ftc_pkg.sv =====
// Shared types, constants and functions for the frequency response table correction block.
// Holds the log2 fraction table, the phase wrap helper and the sequencer states.
// Depends on nothing; ftc_mul, ftc_div and the top level import it, but ftc_ram does not.
`timescale 1ns / 1ps
`default_nettype none
package ftc_pkg;

   // Table size and log table resolution
   localparam int TABLE_POINTS   = 64;
   localparam int LOG_TABLE_BITS = 6;
   localparam int ADDR_W         = $clog2(TABLE_POINTS);
   localparam int CNT_W          = $clog2(TABLE_POINTS + 1);
   localparam int ROM_LEN        = (1 << LOG_TABLE_BITS) + 1;
   localparam int ROM_W          = 17;
   localparam int FRAC_W         = 16;
   localparam int LOG_W          = 22;
   localparam int MUL_A_W        = 31 - LOG_TABLE_BITS;
   localparam int MUL_B_W        = 18;
   localparam int MUL_P_W        = MUL_A_W + 1 + MUL_B_W;
   localparam int PHASE_W        = 19;

   // Phase constants in Q9.7 degrees
   localparam logic signed [PHASE_W-1:0] PHASE_HALF = 19'sd23040;
   localparam logic signed [PHASE_W-1:0] PHASE_FULL = 19'sd46080;

   // Commands
   localparam logic CMD_PROCESS = 1'b0;
   localparam logic CMD_WRITE   = 1'b1;

   // Register indexes
   localparam logic [1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [1:0] CSR_LOG_INTERP  = 2'd1;
   localparam logic [1:0] CSR_CLAMP       = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_ZERO_FREQ = 2'd2,
      STATUS_RANGE     = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_LOG_LOAD,
      S_LOG_NORM,
      S_LOG_MUL,
      S_LOG_ACC,
      S_LOG_DIVSET,
      S_DIV_START,
      S_DIV_WAIT,
      S_GAIN_LO,
      S_GAIN_HI,
      S_GAIN_SUM,
      S_CORR,
      S_PHASE,
      S_FIN,
      S_OUT
   } state_type;

   // One calibration point as stored in the table memory
   typedef struct packed {
      logic [31:0]        freq;
      logic [15:0]        gain;
      logic signed [15:0] phase;
   } point_type;

   localparam int POINT_W = $bits(point_type);

   // Divider request and response
   typedef struct packed {
      logic        start;
      logic [31:0] num;
      logic [31:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quot;
   } div_rsp_type;

   typedef logic [ROM_W-1:0] log_rom_type [ROM_LEN];

   // Build log2(1 + k/2^B) in Q1.16 by repeated square and compare
   function automatic log_rom_type build_log_rom();
      log_rom_type rom;
      logic [63:0] y;
      logic [ROM_W-1:0] acc;
      for (int k = 0; k < ROM_LEN - 1; k++) begin
         y   = 64'(ROM_LEN - 1 + k) << (30 - LOG_TABLE_BITS);
         acc = '0;
         for (int b = 0; b < 16; b++) begin
            y   = (y * y) >> 30;
            acc = acc << 1;
            if (y >= (64'd2 << 30)) begin
               acc[0] = 1'b1;
               y      = y >> 1;
            end
         end
         rom[k] = acc;
      end
      rom[ROM_LEN-1] = 17'd65536;
      return rom;
   endfunction

   localparam log_rom_type LOG_ROM = build_log_rom();

   // Reduce a phase of less than one and a half turns into (-180, 180]
   function automatic logic signed [15:0] wrap_phase(input logic signed [PHASE_W-1:0] x);
      logic signed [PHASE_W-1:0] r;
      r = x;
      if (x > PHASE_HALF) begin
         r = x - PHASE_FULL;
      end else if (x <= -PHASE_HALF) begin
         r = x + PHASE_FULL;
      end
      return r[15:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ftc_ram.sv =====
// Generic simple dual port RAM with one write port and one registered read port.
// Used for the calibration table; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module ftc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/ftc_mul.sv =====
// Shared registered multiplier: unsigned A operand times signed B operand.
// Depends on ftc_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none
module ftc_mul
   import ftc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic [MUL_A_W-1:0]         op_a,
   input  wire logic signed [MUL_B_W-1:0]  op_b,
   output logic signed [MUL_P_W-1:0]       prod
);

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   // Extend A as a positive signed value, then multiply
   assign prod_in = $signed({1'b0, op_a}) * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ===== rtl/ftc_div.sv =====
// Restoring divider, one quotient bit a cycle, for a numerator below the divisor.
// Gives floor(num * 2^16 / den); depends on ftc_pkg for the request types.
`timescale 1ns / 1ps
`default_nettype none
module ftc_div
   import ftc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   localparam int STEP_W = $clog2(FRAC_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [32:0]       rem_ff;
   logic [31:0]       den_ff;
   logic [FRAC_W-1:0] quot_ff;
   logic [32:0]       shifted;
   logic              take;

   // Double the remainder and try the divisor
   assign shifted = {rem_ff[31:0], 1'b0};
   assign take    = shifted >= {1'b0, den_ff};

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(FRAC_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder and quotient
   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= {1'b0, req.num};
         den_ff  <= req.den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= take ? shifted - {1'b0, den_ff} : shifted;
         quot_ff <= {quot_ff[FRAC_W-2:0], take};
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule
`default_nettype wire

// ===== rtl/frequency_response_table_correction.sv =====
// Frequency response table correction. A write request gives no result.
// A process request scans the table through the registered memory port (n points in use),
// then in log mode takes each log2 by normalising shifts, and then uses the divider.
// One request at a time; the next is taken the cycle after the result enters the output register.
// Synchronous active-high reset clears control and configuration; the table is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module frequency_response_table_correction
   import ftc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic [5:0]         req_point_index,
   input  wire logic [31:0]        req_point_frequency,
   input  wire logic [15:0]        req_point_gain,
   input  wire logic signed [15:0] req_point_phase,
   input  wire logic [31:0]        req_measure_frequency,
   input  wire logic [15:0]        req_measured_gain,
   input  wire logic signed [15:0] req_measured_phase,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_applied_gain,
   output logic signed [15:0]      rsp_applied_phase,
   output logic [31:0]             rsp_corrected_gain,
   output logic signed [15:0]      rsp_corrected_phase,
   output logic [15:0]             rsp_fraction,
   output logic [5:0]              rsp_lower_point,
   output logic [5:0]              rsp_upper_point,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [6:0]         csr_data
);

   state_type state_ff, state_in;

   // Configuration
   logic [6:0] count_cfg_ff;
   logic       log_cfg_ff;
   logic       clamp_cfg_ff;

   // Request
   logic [CNT_W-1:0]   n_ff;
   logic [31:0]        f_ff;
   logic [15:0]        mg_ff;
   logic signed [15:0] mp_ff;

   // Scan
   logic [CNT_W-1:0]  issue_ff;
   logic              rd_vld_ff;
   logic [CNT_W-1:0]  rd_idx_ff;
   point_type         prev_ff, w0_ff, wl_ff, lw_ff, uw_ff;
   logic              found_ff, bad_ff;
   logic [ADDR_W-1:0] up_found_ff, lo_idx_ff, up_idx_ff;

   // Log and arithmetic
   logic [1:0]             lsel_ff;
   logic [31:0]            x_ff;
   logic [4:0]             p_ff;
   logic [ROM_W-1:0]       rom_lo_ff;
   logic [LOG_W-1:0]       l_ff [3];
   logic [31:0]            div_num_ff, div_den_ff;
   logic [FRAC_W-1:0]      frac_ff;
   logic [33:0]            acc_ff;
   logic [15:0]            ag_ff;
   logic signed [15:0]     delta_ff;
   logic [31:0]            corr_ff;

   // Result
   status_type         res_status_ff;
   logic [15:0]        res_ag_ff;
   logic signed [15:0] res_ap_ff;
   logic [31:0]        res_cg_ff;
   logic signed [15:0] res_cp_ff;
   logic [15:0]        res_frac_ff;
   logic [5:0]         res_lo_ff, res_up_ff;

   // Output register
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [15:0]        rsp_ag_ff;
   logic signed [15:0] rsp_ap_ff;
   logic [31:0]        rsp_cg_ff;
   logic signed [15:0] rsp_cp_ff;
   logic [15:0]        rsp_frac_ff;
   logic [5:0]         rsp_lo_ff, rsp_up_ff;

   logic req_fire, out_free, push;
   logic [CNT_W-1:0] n_now;

   // Memory and shared units
   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
   point_type                 ram_wdata, ram_rdata;
   logic [MUL_A_W-1:0]        mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   // Log table lookup for the normalised operand
   logic [LOG_TABLE_BITS-1:0] rom_idx;
   logic [ROM_W-1:0]          rom_lo, rom_hi, rom_d;
   logic [MUL_P_W-1:0]        log_tail;
   logic [LOG_W-1:0]          log_val;
   logic [LOG_W-1:0]          log_den, log_num;

   // Phase arithmetic
   logic signed [15:0] ap_now, cp_now;
   logic [33:0]        gain_sum;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign push      = (state_ff == S_OUT) && out_free;

   // Clip the point count to the table size
   assign n_now = (32'(count_cfg_ff) > 32'(TABLE_POINTS)) ? CNT_W'(TABLE_POINTS)
                                                          : CNT_W'(count_cfg_ff);

   assign rom_idx  = x_ff[30 -: LOG_TABLE_BITS];
   assign rom_lo   = LOG_ROM[rom_idx];
   assign rom_hi   = LOG_ROM[{1'b0, rom_idx} + 1'b1];
   assign rom_d    = rom_hi - rom_lo;
   assign log_tail = MUL_P_W'(unsigned'(mul_p)) >> (31 - LOG_TABLE_BITS);
   assign log_val  = (LOG_W'(p_ff) << 16) + LOG_W'(rom_lo_ff) + LOG_W'(log_tail);
   assign log_den  = l_ff[1] - l_ff[0];
   assign log_num  = l_ff[2] - l_ff[0];

   assign gain_sum = acc_ff + 34'(unsigned'(mul_p[33:0]));
   assign ap_now   = wrap_phase(PHASE_W'(lw_ff.phase) + PHASE_W'($signed(mul_p[33:16])));
   assign cp_now   = wrap_phase(PHASE_W'(mp_ff) + PHASE_W'(ap_now));

   ftc_ram #(
      .WIDTH(POINT_W),
      .DEPTH(TABLE_POINTS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ftc_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (mul_p)
   );

   ftc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_command == CMD_PROCESS) begin
               if (n_now == '0 || req_measure_frequency == '0) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff == n_ff && !rd_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (bad_ff) begin
               state_in = S_OUT;
            end else if (f_ff <= w0_ff.freq) begin
               state_in = (f_ff < w0_ff.freq && !clamp_cfg_ff) ? S_OUT : S_GAIN_LO;
            end else if (f_ff >= wl_ff.freq) begin
               state_in = (f_ff > wl_ff.freq && !clamp_cfg_ff) ? S_OUT : S_GAIN_LO;
            end else begin
               state_in = log_cfg_ff ? S_LOG_LOAD : S_DIV_START;
            end
         end
         S_LOG_LOAD: state_in = S_LOG_NORM;
         S_LOG_NORM: begin
            if (x_ff[31]) begin
               state_in = S_LOG_MUL;
            end
         end
         S_LOG_MUL:  state_in = S_LOG_ACC;
         S_LOG_ACC:  state_in = (lsel_ff == 2'd2) ? S_LOG_DIVSET : S_LOG_LOAD;
         S_LOG_DIVSET: begin
            if (log_den == '0 || log_num >= log_den) begin
               state_in = S_GAIN_LO;
            end else begin
               state_in = S_DIV_START;
            end
         end
         S_DIV_START: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = S_GAIN_LO;
            end
         end
         S_GAIN_LO:  state_in = S_GAIN_HI;
         S_GAIN_HI:  state_in = S_GAIN_SUM;
         S_GAIN_SUM: state_in = S_CORR;
         S_CORR:     state_in = S_PHASE;
         S_PHASE:    state_in = S_FIN;
         S_FIN:      state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // Memory, multiplier and divider controls
   always_comb begin
      ram_we        = req_fire && req_command == CMD_WRITE &&
                      (32'(req_point_index) < 32'(TABLE_POINTS));
      ram_waddr     = ADDR_W'(req_point_index);
      ram_wdata     = '{freq: req_point_frequency, gain: req_point_gain,
                        phase: req_point_phase};
      ram_raddr     = issue_ff[ADDR_W-1:0];
      mul_a         = '0;
      mul_b         = '0;
      div_req.start = (state_ff == S_DIV_START);
      div_req.num   = div_num_ff;
      div_req.den   = div_den_ff;
      case (state_ff)
         S_LOG_MUL: begin
            mul_a = MUL_A_W'(x_ff[30-LOG_TABLE_BITS:0]);
            mul_b = MUL_B_W'(rom_d);
         end
         S_GAIN_LO: begin
            mul_a = MUL_A_W'(lw_ff.gain);
            mul_b = MUL_B_W'(17'h10000 - {1'b0, frac_ff});
         end
         S_GAIN_HI: begin
            mul_a = MUL_A_W'(uw_ff.gain);
            mul_b = MUL_B_W'(frac_ff);
         end
         S_CORR: begin
            mul_a = MUL_A_W'(mg_ff);
            mul_b = MUL_B_W'(ag_ff);
         end
         S_PHASE, S_FIN: begin
            mul_a = MUL_A_W'(frac_ff);
            mul_b = MUL_B_W'(delta_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_cfg_ff <= '0;
         log_cfg_ff   <= 1'b0;
         clamp_cfg_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == S_SCAN) && (issue_ff < n_ff);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POINT_COUNT: count_cfg_ff <= csr_data;
               CSR_LOG_INTERP:  log_cfg_ff   <= csr_data[0];
               CSR_CLAMP:       clamp_cfg_ff <= csr_data[0];
               default:         count_cfg_ff <= count_cfg_ff;
            endcase
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            n_ff        <= n_now;
            f_ff        <= req_measure_frequency;
            mg_ff       <= req_measured_gain;
            mp_ff       <= req_measured_phase;
            issue_ff    <= '0;
            found_ff    <= 1'b0;
            bad_ff      <= 1'b0;
            lsel_ff     <= 2'd0;
            frac_ff     <= '0;
            res_ag_ff   <= '0;
            res_ap_ff   <= '0;
            res_cg_ff   <= '0;
            res_cp_ff   <= '0;
            res_frac_ff <= '0;
            res_lo_ff   <= '0;
            res_up_ff   <= '0;
            res_status_ff <= (n_now == '0) ? STATUS_EMPTY : STATUS_ZERO_FREQ;
         end
         S_SCAN: begin
            if (issue_ff < n_ff) begin
               issue_ff  <= issue_ff + 1'b1;
            end
            rd_idx_ff <= issue_ff;
            // Check one point and look for the first one at or above f
            if (rd_vld_ff) begin
               prev_ff <= ram_rdata;
               if (ram_rdata.freq == '0 || ram_rdata.gain == '0 ||
                   (rd_idx_ff != '0 && ram_rdata.freq <= prev_ff.freq)) begin
                  bad_ff <= 1'b1;
               end
               if (rd_idx_ff == '0) begin
                  w0_ff <= ram_rdata;
               end
               if (rd_idx_ff == n_ff - 1'b1) begin
                  wl_ff <= ram_rdata;
               end
               if (!found_ff && rd_idx_ff != '0 && ram_rdata.freq >= f_ff) begin
                  found_ff    <= 1'b1;
                  lw_ff       <= prev_ff;
                  uw_ff       <= ram_rdata;
                  up_found_ff <= rd_idx_ff[ADDR_W-1:0];
               end
            end
         end
         S_DECIDE: begin
            res_status_ff <= STATUS_RANGE;
            div_num_ff    <= f_ff - lw_ff.freq;
            div_den_ff    <= uw_ff.freq - lw_ff.freq;
            if (f_ff <= w0_ff.freq) begin
               lw_ff     <= w0_ff;
               uw_ff     <= w0_ff;
               lo_idx_ff <= '0;
               up_idx_ff <= '0;
            end else if (f_ff >= wl_ff.freq) begin
               lw_ff     <= wl_ff;
               uw_ff     <= wl_ff;
               lo_idx_ff <= ADDR_W'(n_ff - 1'b1);
               up_idx_ff <= ADDR_W'(n_ff - 1'b1);
            end else begin
               lo_idx_ff <= up_found_ff - 1'b1;
               up_idx_ff <= up_found_ff;
            end
         end
         S_LOG_LOAD: begin
            p_ff <= 5'd31;
            case (lsel_ff)
               2'd0:    x_ff <= lw_ff.freq;
               2'd1:    x_ff <= uw_ff.freq;
               default: x_ff <= f_ff;
            endcase
         end
         S_LOG_NORM: begin
            if (!x_ff[31]) begin
               x_ff <= {x_ff[30:0], 1'b0};
               p_ff <= p_ff - 1'b1;
            end
         end
         S_LOG_MUL: begin
            rom_lo_ff <= rom_lo;
         end
         S_LOG_ACC: begin
            l_ff[lsel_ff] <= log_val;
            lsel_ff       <= lsel_ff + 1'b1;
         end
         S_LOG_DIVSET: begin
            div_num_ff <= 32'(log_num);
            div_den_ff <= 32'(log_den);
            if (log_den == '0) begin
               frac_ff <= '0;
            end else if (log_num >= log_den) begin
               frac_ff <= '1;
            end
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               frac_ff <= div_rsp.quot;
            end
         end
         S_GAIN_HI: begin
            acc_ff <= 34'(unsigned'(mul_p[33:0]));
         end
         S_GAIN_SUM: begin
            ag_ff    <= gain_sum[31:16];
            delta_ff <= wrap_phase(PHASE_W'(uw_ff.phase) - PHASE_W'(lw_ff.phase));
         end
         S_PHASE: begin
            corr_ff <= mul_p[31:0];
         end
         S_FIN: begin
            res_status_ff <= STATUS_OK;
            res_ag_ff     <= ag_ff;
            res_ap_ff     <= ap_now;
            res_cg_ff     <= corr_ff;
            res_cp_ff     <= cp_now;
            res_frac_ff   <= frac_ff;
            res_lo_ff     <= 6'(lo_idx_ff);
            res_up_ff     <= 6'(up_idx_ff);
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
      // Load the output register
      if (push) begin
         rsp_status_ff <= res_status_ff;
         rsp_ag_ff     <= res_ag_ff;
         rsp_ap_ff     <= res_ap_ff;
         rsp_cg_ff     <= res_cg_ff;
         rsp_cp_ff     <= res_cp_ff;
         rsp_frac_ff   <= res_frac_ff;
         rsp_lo_ff     <= res_lo_ff;
         rsp_up_ff     <= res_up_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_applied_gain    = rsp_ag_ff;
   assign rsp_applied_phase   = rsp_ap_ff;
   assign rsp_corrected_gain  = rsp_cg_ff;
   assign rsp_corrected_phase = rsp_cp_ff;
   assign rsp_fraction        = rsp_frac_ff;
   assign rsp_lower_point     = rsp_lo_ff;
   assign rsp_upper_point     = rsp_up_ff;

   // A write request never starts a process
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_command == CMD_WRITE |=> state_ff == S_IDLE)
      else $error("write request left the idle state");

   // A new result only comes from the output state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside the output state");

   // The divider only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished unexpectedly");

   // A failed request carries zero gain, corrected gain, fraction and lower point fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_OK |->
         rsp_ag_ff == '0 && rsp_cg_ff == '0 && rsp_frac_ff == '0 && rsp_lo_ff == '0)
      else $error("error result with nonzero fields");

endmodule
`default_nettype wire
